@@ rtl/sra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants shared by the serial request / acknowledge exchange.
// ----------------------------------------------------------------------------
package sra_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // item commands
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_RX_BYTE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_WAIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_WAIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_GAP    = 2'd2;

   localparam logic [15:0] ACK_WAIT_RST    = 16'd100;
   localparam logic [15:0] SECOND_WAIT_RST = 16'd1500;
   localparam logic [7:0]  BYTE_GAP_RST    = 8'd20;

   localparam logic [7:0] SOF_VAR      = 8'hFD;
   localparam logic [7:0] SOF_FIXED    = 8'hEE;
   localparam logic [7:0] REQ_LEN_BYTE = 8'h08;
   localparam logic [7:0] TYPE_NO_SEQ  = 8'h71;
   localparam logic [7:0] TYPE_TWO_ACK = 8'h70;
   localparam logic [7:0] CHAN_A       = 8'd2;
   localparam logic [7:0] CHAN_B       = 8'd4;
   localparam logic [7:0] MIN_VAR_LEN  = 8'd3;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  channel;
      logic [7:0]  head;
      logic [7:0]  seq_num;
      logic [7:0]  msg_type;
      logic [7:0]  dev_addr;
      logic [15:0] payload;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      frame_type bytes;
      logic      need_second;
   } req_info_type;

   typedef struct packed {
      logic             load;
      logic [1:0]       kind;
      logic [CNT_W-1:0] len;
   } rsp_load_type;

endpackage

@@ rtl/serial_request_ack_exchange.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_request_ack_exchange
// Sends a request frame and collects acknowledge frames from a serial line.
//
// Channels: req_* takes items (start request, received line byte, time tick);
// rsp_* gives results (transmit byte, acknowledge byte, failure). An item is
// taken when valid is high and stall is low on the same edge. csr_* writes
// the three timing registers; the user must write them only while the block
// is idle, which the block itself does not enforce. The first result of an
// item shows in the cycle after it is taken. A start gives eight transmit
// bytes, a good acknowledge frame gives its three to eight bytes, and a wait
// timeout gives one failure. Throughput: with no result group pending an
// item is taken every cycle. While a group is handed out req_stall stays
// high until its last result is taken, so an item behind a group waits for
// all its results (up to eight), set by the single result buffer. When the
// receiver stalls, the current result holds and the input side stays
// stalled with it. Reset: synchronous, clears the exchange to idle and loads
// the register defaults (100, 1500 and 20 ticks). No clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_request_ack_exchange (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sra_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sra_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_we,
   input  logic [sra_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [sra_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sra_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND} phase_type;
   typedef enum logic [1:0] {FK_NONE, FK_VAR, FK_FIXED} fkind_type;

   phase_type        phase_ff, phase_in;
   fkind_type        fkind_ff, fkind_in;
   logic             need_second_ff, need_second_in;
   frame_type        frame_store_ff, frame_store_in;
   logic [CNT_W-1:0] frame_count_ff, frame_count_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic [7:0]       gap_timer_ff, gap_timer_in;
   logic [15:0]      wait_timer_ff, wait_timer_in;
   logic [15:0]      ack_wait_ff, ack_wait_in;
   logic [15:0]      second_wait_ff, second_wait_in;
   logic [7:0]       byte_gap_ff, byte_gap_in;

   req_info_type     info;
   rsp_load_type     ld;
   frame_type        ld_data;
   logic             q_free;
   logic             accept;
   logic [7:0]       rx;
   logic [IDX_W-1:0] wr_idx;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       target;
   logic [7:0]       gap_dec;
   logic [15:0]      wait_dec;
   logic             frame_live;

   sra_req_build u_build (
      .req  (req_payload),
      .info (info)
   );

   sra_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld),
      .ld_data     (ld_data),
      .free        (q_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = !q_free;
   assign accept    = req_valid && q_free;
   assign rx        = req_payload.rx_byte;
   assign wr_idx    = frame_count_ff[IDX_W-1:0];
   assign cnt_inc   = frame_count_ff + CNT_W'(1);
   assign gap_dec   = (gap_timer_ff != 8'd0) ? gap_timer_ff - 8'd1 : 8'd0;
   assign wait_dec  = (wait_timer_ff != 16'd0) ? wait_timer_ff - 16'd1 : 16'd0;
   // the length byte is the frame's second byte; it may be arriving right now
   assign target    = (fkind_ff == FK_VAR) ?
                      ((frame_count_ff == CNT_W'(1)) ? rx : frame_store_ff[1]) :
                      8'(FRAME_BYTES);

   always_comb begin
      phase_in       = phase_ff;
      fkind_in       = fkind_ff;
      need_second_in = need_second_ff;
      frame_store_in = frame_store_ff;
      frame_count_in = frame_count_ff;
      running_xor_in = running_xor_ff;
      gap_timer_in   = gap_timer_ff;
      wait_timer_in  = wait_timer_ff;
      ack_wait_in    = ack_wait_ff;
      second_wait_in = second_wait_ff;
      byte_gap_in    = byte_gap_ff;
      ld             = '0;
      ld_data        = info.bytes;
      frame_live     = fkind_ff != FK_NONE;

      if (csr_we) begin
         case (csr_addr)
            CSR_ACK_WAIT:    ack_wait_in    = csr_wdata;
            CSR_SECOND_WAIT: second_wait_in = csr_wdata;
            CSR_BYTE_GAP:    byte_gap_in    = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (accept) begin
         case (req_payload.cmd)
            CMD_START: begin
               ld.load        = 1'b1;
               ld.kind        = KIND_TX;
               ld.len         = CNT_W'(FRAME_BYTES);
               fkind_in       = FK_NONE;
               frame_count_in = '0;
               running_xor_in = '0;
               gap_timer_in   = '0;
               need_second_in = info.need_second;
               phase_in       = PH_FIRST;
               wait_timer_in  = ack_wait_ff;
            end
            CMD_RX_BYTE: begin
               if (phase_ff != PH_IDLE) begin
                  if (fkind_ff == FK_NONE) begin
                     // only a start byte opens a frame
                     if (rx == SOF_VAR || rx == SOF_FIXED) begin
                        frame_store_in[0] = rx;
                        frame_count_in    = CNT_W'(1);
                        running_xor_in    = rx;
                        fkind_in          = (rx == SOF_VAR) ? FK_VAR : FK_FIXED;
                        gap_timer_in      = byte_gap_ff;
                     end
                  end else if (frame_count_ff >= CNT_W'(FRAME_BYTES)) begin
                     fkind_in       = FK_NONE;
                     frame_count_in = '0;
                     running_xor_in = '0;
                     gap_timer_in   = '0;
                  end else begin
                     frame_store_in[wr_idx] = rx;
                     frame_count_in         = cnt_inc;
                     if (fkind_ff == FK_VAR && frame_count_ff == CNT_W'(1) &&
                         (rx < MIN_VAR_LEN || rx > 8'(FRAME_BYTES))) begin
                        fkind_in       = FK_NONE;
                        frame_count_in = '0;
                        running_xor_in = '0;
                        gap_timer_in   = '0;
                     end else if (8'(cnt_inc) == target) begin
                        fkind_in       = FK_NONE;
                        frame_count_in = '0;
                        running_xor_in = '0;
                        gap_timer_in   = '0;
                        if (rx == running_xor_ff) begin
                           if (phase_ff == PH_FIRST && need_second_ff) begin
                              // first of two acknowledges is swallowed
                              phase_in      = PH_SECOND;
                              wait_timer_in = second_wait_ff;
                           end else begin
                              ld.load        = 1'b1;
                              ld.kind        = KIND_ACK;
                              ld.len         = cnt_inc;
                              ld_data        = frame_store_in;
                              phase_in       = PH_IDLE;
                              need_second_in = 1'b0;
                              wait_timer_in  = '0;
                           end
                        end
                     end else begin
                        running_xor_in = running_xor_ff ^ rx;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (frame_live) begin
                     gap_timer_in = gap_dec;
                     if (gap_dec == 8'd0) begin
                        frame_live     = 1'b0;
                        fkind_in       = FK_NONE;
                        frame_count_in = '0;
                        running_xor_in = '0;
                     end
                  end
                  wait_timer_in = wait_dec;
                  // a frame in flight holds off the failure until it ends
                  if (wait_dec == 16'd0 && !frame_live) begin
                     ld.load        = 1'b1;
                     ld.kind        = KIND_FAIL;
                     ld.len         = CNT_W'(1);
                     ld_data        = '0;
                     phase_in       = PH_IDLE;
                     need_second_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      frame_store_ff <= frame_store_in;
      if (reset) begin
         phase_ff       <= PH_IDLE;
         fkind_ff       <= FK_NONE;
         need_second_ff <= 1'b0;
         frame_count_ff <= '0;
         running_xor_ff <= '0;
         gap_timer_ff   <= '0;
         wait_timer_ff  <= '0;
         ack_wait_ff    <= ACK_WAIT_RST;
         second_wait_ff <= SECOND_WAIT_RST;
         byte_gap_ff    <= BYTE_GAP_RST;
      end else begin
         phase_ff       <= phase_in;
         fkind_ff       <= fkind_in;
         need_second_ff <= need_second_in;
         frame_count_ff <= frame_count_in;
         running_xor_ff <= running_xor_in;
         gap_timer_ff   <= gap_timer_in;
         wait_timer_ff  <= wait_timer_in;
         ack_wait_ff    <= ack_wait_in;
         second_wait_ff <= second_wait_in;
         byte_gap_ff    <= byte_gap_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fail_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == KIND_FAIL) |->
         (rsp_payload.last && rsp_payload.data_byte == 8'h00))
      else $error("failure item is not a single last zero item");

   a_start_head : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.cmd == CMD_START) |=>
         (rsp_valid && rsp_payload.kind == KIND_TX &&
          rsp_payload.data_byte == $past(req_payload.head)))
      else $error("request frame does not open with its head byte");

   a_frame_count : assert property (@(posedge clock) disable iff (reset)
      (frame_count_ff <= CNT_W'(FRAME_BYTES)) &&
      ((fkind_ff == FK_NONE) == (frame_count_ff == '0)))
      else $error("frame count out of step with frame kind");

   a_stall_busy : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");
`endif

endmodule

@@ rtl/sra_req_build.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_req_build
// Assembles the outgoing request frame with its check byte, and decides
// whether the exchange needs a second acknowledge.
// ----------------------------------------------------------------------------
module sra_req_build (
   input  sra_pkg::req_type      req,
   output sra_pkg::req_info_type info
);
   import sra_pkg::*;

   logic [7:0] chk;
   frame_type  frm;

   always_comb begin
      frm    = '0;
      frm[0] = req.head;
      frm[1] = REQ_LEN_BYTE;
      // sequence is zeroed for this one channel / type pair
      frm[2] = (req.channel == CHAN_A && req.msg_type == TYPE_NO_SEQ) ? 8'h00 : req.seq_num;
      frm[3] = req.msg_type;
      frm[4] = req.dev_addr;
      frm[5] = req.payload[7:0];
      frm[6] = req.payload[15:8];
      chk    = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         chk = chk ^ frm[i];
      end
      frm[FRAME_BYTES-1] = chk;
   end

   assign info.bytes       = frm;
   assign info.need_second = (req.msg_type == TYPE_TWO_ACK) &&
                             (req.channel == CHAN_A || req.channel == CHAN_B);

endmodule

@@ rtl/sra_rsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_rsp_queue
// Holds the results of one item and hands them out one per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module sra_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sra_pkg::rsp_load_type ld,
   input  sra_pkg::frame_type    ld_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sra_pkg::rsp_type      rsp_payload
);
   import sra_pkg::*;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] len_ff;
   logic [1:0]       kind_ff;
   frame_type        data_ff;
   logic             last;
   logic             pop;

   assign last = (CNT_W'(idx_ff) == len_ff - CNT_W'(1));
   assign pop  = valid_ff && !rsp_stall;
   assign free = !valid_ff || (pop && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (ld.load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.load) begin
         data_ff <= ld_data;
         len_ff  <= ld.len;
         kind_ff <= ld.kind;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_payload.kind      = kind_ff;
   assign rsp_payload.data_byte = data_ff[idx_ff];
   assign rsp_payload.last      = last;

endmodule
